[rtl/b64c_pkg.sv]
// Package for the base64 codec: shared types, constants and the alphabet mapping functions.
// Has no dependencies; every other file in rtl but b64c_if imports it.
package b64c_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } b64c_dir_t;

  // A group of up to four results that one input item releases.
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [1:0]      cnt_m1;
    logic            last;
    logic            err;
  } b64c_job_t;

  function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

  function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
    logic [7:0] r;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      r = 8'd62;
    end else if (c == 8'h2F) begin
      r = 8'd63;
    end else begin
      r = 8'd0;
    end
    return r[5:0];
  endfunction

endpackage

[rtl/b64c_if.sv]
// Channel interfaces of the base64 codec: input items and result items.
// Has no dependencies.
interface b64c_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_in;
  logic       last_in;

  modport source (output valid, output data_in, output last_in, input ready);
  modport sink   (input valid, input data_in, input last_in, output ready);
endinterface

interface b64c_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic       last_out;
  logic       length_error;

  modport source (output valid, output data_out, output last_out, output length_error,
                  input ready);
  modport sink   (input valid, input data_out, input last_out, input length_error,
                  output ready);
endinterface

[rtl/base64_codec_core.sv]
// Top level of the streaming base64 codec: group stage followed by the output stage.
// Depends on b64c_pkg, b64c_if, b64c_group and b64c_burst.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------
//  in_ch    | in  | valid / ready      | data_in[7:0], last_in
//  out_ch   | out | valid / ready      | data_out[7:0], last_out, length_error
//  cfg      | in  | cfg_we (no wait)   | cfg_wdata: direction, 0 encode, 1 decode
//
// An input item can be accepted in every cycle while the job register is free or is
// being handed to the output stage in the same cycle. An item that completes a group
// (three bytes, four characters, or any item marked last) releases one to four results,
// the first of them once it has passed the job register and the burst register; results
// then leave one per cycle while out_ch.ready is high, so when encoding the single
// output port sets the sustained rate.
// Reset is synchronous and active low and clears the direction (to encode), the partial
// group and both valid flags. A stalled output holds its result and, once the job
// register is also full, lowers in_ch.ready until the output stage frees.
module base64_codec_core import b64c_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  b64c_in_if.sink       in_ch,
  b64c_out_if.source    out_ch
);

  // Handoff between the two stages: the job register feeds the burst register
  // whenever the latter is empty or is sending its final result.
  logic      job_valid;
  logic      job_take;
  b64c_job_t job;

  b64c_group u_group (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .job_take  (job_take),
    .job_valid (job_valid),
    .job       (job)
  );

  b64c_burst u_burst (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take),
    .out_ch    (out_ch)
  );

endmodule

[rtl/b64c_group.sv]
// Group stage of the base64 codec: direction register, group accumulator and job register.
// Depends on b64c_pkg and b64c_in_if.
module b64c_group import b64c_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  b64c_in_if.sink       in_ch,
  input  logic          job_take,
  output logic          job_valid,
  output b64c_job_t     job
);

  b64c_dir_t   dir_r;
  logic [23:0] grp_bits_r, grp_bits_nxt;
  logic [1:0]  grp_cnt_r, grp_cnt_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic        job_valid_r;
  b64c_job_t   job_r, job_nxt;
  logic        done;
  logic        accept;
  logic [1:0]  cnt;
  logic [23:0] triple;
  logic [1:0]  nbytes_m1;

  assign in_ch.ready = !job_valid_r || job_take;
  assign accept      = in_ch.valid && in_ch.ready;
  assign job_valid   = job_valid_r;
  assign job         = job_r;

  always_comb begin
    done      = 1'b0;
    pad_nxt   = pad_r;
    cnt       = grp_cnt_r + 2'd1;
    triple    = '0;
    nbytes_m1 = 2'd2;
    job_nxt   = '0;
    if (dir_r == DIR_ENCODE) begin
      grp_bits_nxt = {grp_bits_r[15:0], in_ch.data_in};
      done         = (cnt == 2'd3) || in_ch.last_in;
      case (cnt)
        2'd1:    triple = {grp_bits_nxt[7:0], 16'h0000};
        2'd2:    triple = {grp_bits_nxt[15:0], 8'h00};
        default: triple = grp_bits_nxt;
      endcase
      for (int k = 0; k < 4; k++) begin
        if (k > int'(cnt)) begin
          job_nxt.data[k] = PAD_CHAR;
        end else begin
          job_nxt.data[k] = sextet_to_char(triple[23 - 6 * k -: 6]);
        end
      end
      job_nxt.cnt_m1 = 2'd3;
      job_nxt.last   = in_ch.last_in;
    end else begin
      if (grp_cnt_r >= 2'd2 && in_ch.data_in == PAD_CHAR) begin
        pad_nxt = pad_r + 2'd1;
      end
      grp_bits_nxt = {grp_bits_r[17:0], char_to_sextet(in_ch.data_in)};
      if (grp_cnt_r != 2'd3) begin
        // A stream that stops inside a quad gives a single error result.
        done           = in_ch.last_in;
        job_nxt.cnt_m1 = 2'd0;
        job_nxt.last   = 1'b1;
        job_nxt.err    = 1'b1;
      end else begin
        done = 1'b1;
        // Padding only shortens the final quad of the stream.
        if (in_ch.last_in) begin
          nbytes_m1 = 2'd2 - pad_nxt;
        end
        for (int k = 0; k < 3; k++) begin
          job_nxt.data[k] = grp_bits_nxt[23 - 8 * k -: 8];
        end
        job_nxt.cnt_m1 = nbytes_m1;
        job_nxt.last   = in_ch.last_in;
      end
    end
    grp_cnt_nxt = done ? 2'd0 : cnt;
    if (done) begin
      grp_bits_nxt = '0;
      pad_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r       <= DIR_ENCODE;
      grp_bits_r  <= '0;
      grp_cnt_r   <= '0;
      pad_r       <= '0;
      job_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        dir_r      <= b64c_dir_t'(cfg_wdata);
        grp_bits_r <= '0;
        grp_cnt_r  <= '0;
        pad_r      <= '0;
      end else if (accept) begin
        grp_bits_r <= grp_bits_nxt;
        grp_cnt_r  <= grp_cnt_nxt;
        pad_r      <= pad_nxt;
      end
      if (accept && done) begin
        job_valid_r <= 1'b1;
      end else if (job_take) begin
        job_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && done) begin
      job_r <= job_nxt;
    end
  end

endmodule

[rtl/b64c_burst.sv]
// Output stage of the base64 codec: holds one job and sends its results one per cycle while out_ch.ready is high.
// Depends on b64c_pkg and b64c_out_if.
module b64c_burst import b64c_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  b64c_job_t     job,
  output logic          job_take,
  b64c_out_if.source    out_ch
);

  b64c_job_t  burst_r;
  logic       valid_r;
  logic [1:0] idx_r;
  logic       at_end;
  logic       burst_free;

  assign at_end     = (idx_r == burst_r.cnt_m1);
  assign burst_free = !valid_r || (out_ch.ready && at_end);
  assign job_take   = job_valid && burst_free;

  assign out_ch.valid        = valid_r;
  assign out_ch.data_out     = burst_r.data[idx_r];
  assign out_ch.last_out     = burst_r.last && at_end;
  assign out_ch.length_error = burst_r.err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (job_take) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (valid_r && out_ch.ready) begin
      if (at_end) begin
        valid_r <= 1'b0;
      end
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      burst_r <= job;
    end
  end

`ifndef SYNTH
  a_load_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    job_take |=> (valid_r && idx_r == 2'd0))
    else $error("burst did not restart at its first result");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (idx_r <= burst_r.cnt_m1))
    else $error("burst index beyond its result count");

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && burst_r.err) |-> (out_ch.last_out && out_ch.data_out == 8'h00))
    else $error("error result is not a final zero result");
`endif

endmodule
